// File: rtl/core/dqr_pkg.sv
// Shared types and constants for the DNS query reflect rewriter.
`default_nettype none
package dqr_pkg;

	// Fixed layout of an IPv4 packet with a 20-byte header and a UDP header.
	localparam int IP_HDR_BYTES    = 20;
	localparam int MIN_PKT_BYTES   = 28;
	localparam int OFF_PROTO       = 9;
	localparam int OFF_HCK_HI      = 10;
	localparam int OFF_HCK_LO      = 11;
	localparam int OFF_SRC_ADDR    = 12;
	localparam int OFF_DST_ADDR    = 16;
	localparam int OFF_SRC_PORT    = 20;
	localparam int OFF_DST_PORT_HI = 22;
	localparam int OFF_DST_PORT_LO = 23;
	localparam int OFF_UCK_HI      = 26;
	localparam int OFF_UCK_LO      = 27;
	localparam int OFF_DNS_FLAGS   = 30;
	localparam logic [7:0] DNS_QR_BIT  = 8'h80;
	localparam logic [7:0] UDP_PROTO   = 8'd17;
	localparam logic [15:0] RST_MATCH_PORT = 16'd53;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PORT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PROTO = 1'b1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		ST_DATA      = 3'd0,
		ST_READY     = 3'd1,
		ST_NOT_QUERY = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_EMPTY     = 3'd5
	} dqr_status_t;

	// Where a result byte comes from.
	typedef enum logic [2:0] {
		SRC_ZERO,
		SRC_MEM,
		SRC_QR,
		SRC_HCK_HI,
		SRC_HCK_LO,
		SRC_UCK_HI,
		SRC_UCK_LO
	} dqr_src_t;

	// One loaded byte as seen by the checksum accumulators.
	typedef struct packed {
		logic       en;      // byte is stored
		logic       first;   // first byte of a packet
		logic       lo;      // odd offset, low half of a 16-bit word
		logic       hdr;     // counts toward the IPv4 header sum
		logic       dgm;     // counts toward the UDP pseudo-header and segment sum
		logic       fold;    // packet accepted, compute both checksums
		logic [7:0] value;   // byte value after the response bit is applied
	} dqr_csum_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/dqr_csum.sv
// Incremental ones' complement accumulators and checksum fold for the rewriter.
`default_nettype none
module dqr_csum (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dqr_pkg::dqr_csum_ctl_t ctl,
	input  wire logic [15:0]            udp_len,
	output logic [15:0]                 hck,
	output logic [15:0]                 uck
);

	logic [19:0] hsum_q;
	logic [25:0] dsum_q;
	logic        fold_pend_q;
	logic [15:0] ulen_q;
	logic [15:0] hck_q;
	logic [15:0] uck_q;
	logic [15:0] word;
	logic [26:0] utotal;
	logic [16:0] hf1;
	logic [15:0] hf2;
	logic [16:0] uf1;
	logic [15:0] uf2;
	logic [15:0] uck_raw;

	assign word = ctl.lo ? {8'h00, ctl.value} : {ctl.value, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= '0;
			dsum_q <= '0;
		end else if (ctl.en) begin
			if (ctl.first) begin
				hsum_q <= ctl.hdr ? 20'(word) : '0;
				dsum_q <= ctl.dgm ? 26'(word) : '0;
			end else begin
				if (ctl.hdr) hsum_q <= hsum_q + 20'(word);
				if (ctl.dgm) dsum_q <= dsum_q + 26'(word);
			end
		end
	end

	// The fold runs the cycle after the final byte, from the finished sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_pend_q <= 1'b0;
		end else begin
			fold_pend_q <= ctl.fold;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fold) ulen_q <= udp_len;
		if (fold_pend_q) begin
			hck_q <= ~hf2;
			uck_q <= uck_raw;
		end
	end

	always_comb begin
		hf1     = 17'(hsum_q[15:0]) + 17'(hsum_q[19:16]);
		hf2     = hf1[15:0] + 16'(hf1[16]);
		utotal  = 27'(dsum_q) + 27'(ulen_q) + 27'(dqr_pkg::UDP_PROTO);
		uf1     = 17'(utotal[15:0]) + 17'(utotal[26:16]);
		uf2     = uf1[15:0] + 16'(uf1[16]);
		uck_raw = (uf2 == 16'hffff) ? 16'hffff : ~uf2;
	end

	assign hck = hck_q;
	assign uck = uck_q;

endmodule
`default_nettype wire

// File: rtl/core/dns_query_reflect_rewriter_unit.sv
// Top level of the DNS query reflect rewriter: packet store, control and result path.
`default_nettype none
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ----------------------------------------
// in       input      in_valid / in_stall  kind, data_byte, last_byte
// out      output     out_valid/out_stall  out_byte, out_last, status, packet_length
// cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// One item is taken per cycle while the result path flows; an item's result
// passes through the stage 1 register (the packet store read) and the output
// register. The store is written on the load edge and read on the read edge.
// Reset clears all control state and sets the match registers to port 53
// and UDP; the packet store keeps its contents. A stall on the output holds
// the result register and the stage behind it, and in_stall rises once both
// are full.
// Loaded bytes go to the store unchanged. The swap of addresses and ports is
// done by remapping the read address, the response bit is set as byte 30 is
// read, and the two checksums come from registers that the checksum unit fills
// the cycle after an accepted packet's final byte. Checksum sums grow by one
// byte per stored load item, so the rewrite needs no pass of its own.
module dns_query_reflect_rewriter_unit #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           kind,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           last_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                out_last,
	output logic [2:0]                          status,
	output logic [9:0]                          packet_length,
	input  wire logic                           cfg_wr_en,
	input  wire logic [dqr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dqr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int LCW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int AW  = $clog2(MAX_PACKET_BYTES);

	// Packet store.
	logic [7:0] mem [MAX_PACKET_BYTES];

	// Control state.
	logic [LCW-1:0]  load_cnt_q;
	logic            ovf_q;
	logic [LCW-1:0]  rptr_q;
	logic            ready_q;
	logic [LCW-1:0]  rlen_q;
	logic [15:0]     match_port_q;
	logic [7:0]      match_proto_q;
	logic            s1_vld_q;
	logic            out_vld_q;

	// Header bytes needed for the match test.
	logic [7:0]      proto_q;
	logic [7:0]      dport_hi_q;
	logic [7:0]      dport_lo_q;

	// Stage 1 and output registers.
	dqr_pkg::dqr_status_t status_s1;
	dqr_pkg::dqr_src_t    src_s1;
	logic                 last_s1;
	logic [9:0]           len_s1;
	logic [7:0]           rd_s1;
	dqr_pkg::dqr_status_t out_status_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;
	logic [9:0]           out_len_q;

	// Decode.
	logic                 out_adv;
	logic                 acc;
	logic                 acc_load;
	logic                 acc_read;
	logic                 store;
	logic [LCW-1:0]       len;
	logic [LCW+9:0]       len_ext;
	logic                 ovf;
	dqr_pkg::dqr_status_t load_status;
	logic                 rd_ok;
	logic [LCW-1:0]       rptr_nx;
	logic                 rd_last;
	logic [AW-1:0]        ra;
	dqr_pkg::dqr_src_t    rd_src;
	dqr_pkg::dqr_csum_ctl_t csum_ctl;
	logic [15:0]          udp_len;
	logic [15:0]          hck;
	logic [15:0]          uck;
	logic [7:0]           s1_byte;

	assign out_adv  = !out_vld_q || !out_stall;
	assign in_stall = s1_vld_q && !out_adv;
	assign acc      = in_valid && !in_stall;
	assign acc_load = acc && !kind;
	assign acc_read = acc && kind;

	// Load side: length, overflow and the checks in their order of priority.
	always_comb begin
		store   = load_cnt_q < LCW'(MAX_PACKET_BYTES);
		len     = store ? load_cnt_q + LCW'(1) : load_cnt_q;
		len_ext = {10'b0, len};
		ovf     = ovf_q || !store;
		udp_len = 16'(len) - 16'(dqr_pkg::IP_HDR_BYTES);
		if (ovf) begin
			load_status = dqr_pkg::ST_TOO_LONG;
		end else if (len < LCW'(dqr_pkg::MIN_PKT_BYTES)) begin
			load_status = dqr_pkg::ST_TOO_SHORT;
		end else if (proto_q != match_proto_q ||
				{dport_hi_q, dport_lo_q} != match_port_q) begin
			load_status = dqr_pkg::ST_NOT_QUERY;
		end else begin
			load_status = dqr_pkg::ST_READY;
		end
	end

	// Per-byte control for the checksum unit. The checksum fields count as
	// zero, and byte 30 enters with the response bit already set.
	always_comb begin
		csum_ctl.en    = acc_load && store;
		csum_ctl.first = load_cnt_q == '0;
		csum_ctl.lo    = load_cnt_q[0];
		csum_ctl.hdr   = load_cnt_q < LCW'(dqr_pkg::IP_HDR_BYTES) &&
				load_cnt_q != LCW'(dqr_pkg::OFF_HCK_HI) &&
				load_cnt_q != LCW'(dqr_pkg::OFF_HCK_LO);
		csum_ctl.dgm   = load_cnt_q >= LCW'(dqr_pkg::OFF_SRC_ADDR) &&
				load_cnt_q != LCW'(dqr_pkg::OFF_UCK_HI) &&
				load_cnt_q != LCW'(dqr_pkg::OFF_UCK_LO);
		csum_ctl.fold  = acc_load && last_byte && load_status == dqr_pkg::ST_READY;
		csum_ctl.value = (load_cnt_q == LCW'(dqr_pkg::OFF_DNS_FLAGS)) ?
				(data_byte | dqr_pkg::DNS_QR_BIT) : data_byte;
	end

	// Read side: the address swap is an address remap, the checksum bytes are
	// replaced and the flag byte gets the response bit on its way out.
	always_comb begin
		rd_ok   = ready_q && rptr_q < rlen_q;
		rptr_nx = rptr_q + LCW'(1);
		rd_last = rptr_nx >= rlen_q;
		ra      = rptr_q[AW-1:0];
		rd_src  = dqr_pkg::SRC_MEM;
		if (rptr_q < LCW'(32)) begin
			case (int'(rptr_q[4:0]))
				dqr_pkg::OFF_SRC_ADDR, dqr_pkg::OFF_SRC_ADDR + 1,
				dqr_pkg::OFF_SRC_ADDR + 2, dqr_pkg::OFF_SRC_ADDR + 3: begin
					ra = rptr_q[AW-1:0] + AW'(4);
				end
				dqr_pkg::OFF_DST_ADDR, dqr_pkg::OFF_DST_ADDR + 1,
				dqr_pkg::OFF_DST_ADDR + 2, dqr_pkg::OFF_DST_ADDR + 3: begin
					ra = rptr_q[AW-1:0] - AW'(4);
				end
				dqr_pkg::OFF_SRC_PORT, dqr_pkg::OFF_SRC_PORT + 1: begin
					ra = rptr_q[AW-1:0] + AW'(2);
				end
				dqr_pkg::OFF_DST_PORT_HI, dqr_pkg::OFF_DST_PORT_LO: begin
					ra = rptr_q[AW-1:0] - AW'(2);
				end
				dqr_pkg::OFF_HCK_HI:    rd_src = dqr_pkg::SRC_HCK_HI;
				dqr_pkg::OFF_HCK_LO:    rd_src = dqr_pkg::SRC_HCK_LO;
				dqr_pkg::OFF_UCK_HI:    rd_src = dqr_pkg::SRC_UCK_HI;
				dqr_pkg::OFF_UCK_LO:    rd_src = dqr_pkg::SRC_UCK_LO;
				dqr_pkg::OFF_DNS_FLAGS: rd_src = dqr_pkg::SRC_QR;
				default: begin
				end
			endcase
		end
	end

	dqr_csum u_csum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (csum_ctl),
		.udp_len (udp_len),
		.hck     (hck),
		.uck     (uck)
	);

	// Store write, store read and the captured match bytes.
	always_ff @(posedge clk) begin
		if (acc_load && store) begin
			mem[load_cnt_q[AW-1:0]] <= data_byte;
			if (load_cnt_q == LCW'(dqr_pkg::OFF_PROTO)) proto_q <= data_byte;
			if (load_cnt_q == LCW'(dqr_pkg::OFF_DST_PORT_HI)) dport_hi_q <= data_byte;
			if (load_cnt_q == LCW'(dqr_pkg::OFF_DST_PORT_LO)) dport_lo_q <= data_byte;
		end
		if (acc_read) rd_s1 <= mem[ra];
	end

	// Packet and read pointer control, configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q    <= '0;
			ovf_q         <= 1'b0;
			rptr_q        <= '0;
			ready_q       <= 1'b0;
			rlen_q        <= '0;
			match_port_q  <= dqr_pkg::RST_MATCH_PORT;
			match_proto_q <= dqr_pkg::UDP_PROTO;
		end else begin
			if (acc_load) begin
				if (last_byte) begin
					load_cnt_q <= '0;
					ovf_q      <= 1'b0;
					rptr_q     <= '0;
					ready_q    <= load_status == dqr_pkg::ST_READY;
					if (load_status == dqr_pkg::ST_READY) rlen_q <= len;
				end else begin
					ready_q    <= 1'b0;
					load_cnt_q <= len;
					ovf_q      <= ovf;
				end
			end else if (acc_read) begin
				if (!rd_ok) begin
					ready_q <= 1'b0;
				end else begin
					rptr_q <= rptr_nx;
					if (rd_last) ready_q <= 1'b0;
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					dqr_pkg::REG_MATCH_PORT:  match_port_q  <= cfg_data;
					dqr_pkg::REG_MATCH_PROTO: match_proto_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Valid flags of stage 1 and the output register. A load byte that is
	// not the last one makes no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_vld_q <= kind || last_byte;
			end else if (out_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (out_adv) out_vld_q <= s1_vld_q;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (kind) begin
				len_s1 <= '0;
				if (rd_ok) begin
					status_s1 <= dqr_pkg::ST_DATA;
					src_s1    <= rd_src;
					last_s1   <= rd_last;
				end else begin
					status_s1 <= dqr_pkg::ST_EMPTY;
					src_s1    <= dqr_pkg::SRC_ZERO;
					last_s1   <= 1'b0;
				end
			end else begin
				status_s1 <= load_status;
				src_s1    <= dqr_pkg::SRC_ZERO;
				last_s1   <= 1'b0;
				len_s1    <= (load_status == dqr_pkg::ST_READY) ? len_ext[9:0] : '0;
			end
		end
	end

	always_comb begin
		case (src_s1)
			dqr_pkg::SRC_MEM:    s1_byte = rd_s1;
			dqr_pkg::SRC_QR:     s1_byte = rd_s1 | dqr_pkg::DNS_QR_BIT;
			dqr_pkg::SRC_HCK_HI: s1_byte = hck[15:8];
			dqr_pkg::SRC_HCK_LO: s1_byte = hck[7:0];
			dqr_pkg::SRC_UCK_HI: s1_byte = uck[15:8];
			dqr_pkg::SRC_UCK_LO: s1_byte = uck[7:0];
			default:             s1_byte = 8'h00;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_adv && s1_vld_q) begin
			out_status_q <= status_s1;
			out_byte_q   <= s1_byte;
			out_last_q   <= last_s1;
			out_len_q    <= len_s1;
		end
	end

	assign out_valid     = out_vld_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign status        = out_status_q;
	assign packet_length = out_len_q;

endmodule
`default_nettype wire

// File: tb/dns_query_reflect_rewriter_unit_tb.sv
// Self-checking testbench for the DNS query reflect rewriter unit.
module dns_query_reflect_rewriter_unit_tb;

	localparam int MAX_BYTES = 512;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;
	// Each side idles in about this many cycles of a hundred.
	localparam int IDLE_PCT = 19;
	// Quiet cycles after the last result: covers the two-stage result path and any
	// load item still in flight that produces no result of its own.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 400;

	// One result item as the block presents it.
	typedef struct packed {
		logic [7:0]           data;
		logic                 fin;
		dqr_pkg::dqr_status_t st;
		logic [9:0]           len;
	} reply_t;

	localparam reply_t EMPTY_REPLY = '{8'h00, 1'b0, dqr_pkg::ST_EMPTY, 10'd0};

	typedef enum logic [1:0] {ROW_PACKET, ROW_READ, ROW_DRAIN, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_CK0} fill_t;

	localparam logic [9:0] ROW_PORT_IDX  = 10'(dqr_pkg::REG_MATCH_PORT);
	localparam logic [9:0] ROW_PROTO_IDX = 10'(dqr_pkg::REG_MATCH_PROTO);

	// A row of the directed plan. For packets, num is the length; for reads, the
	// number of read items; for register writes, the register index with the value
	// in the port field. Where typed is set, st (and the length for a ready packet)
	// is the expected result written out by hand.
	typedef struct packed {
		row_kind_t            what;
		logic [9:0]           num;
		logic [15:0]          port;
		logic [7:0]           proto;
		fill_t                fill;
		logic                 typed;
		dqr_pkg::dqr_status_t st;
	} plan_row_t;

	plan_row_t plan [0:27] = '{
		// A read straight after reset finds nothing.
		'{ROW_READ,   10'd1,   16'd0,    8'd0,  FILL_RAND, 1'b1, dqr_pkg::ST_EMPTY},
		// Shortest packet that can be accepted, then read back in full.
		'{ROW_PACKET, 10'd28,  16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_READY},
		'{ROW_DRAIN,  10'd0,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_READ,   10'd1,   16'd0,    8'd0,  FILL_RAND, 1'b1, dqr_pkg::ST_EMPTY},
		// One byte short of the UDP header, and a single byte.
		'{ROW_PACKET, 10'd27,  16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_TOO_SHORT},
		'{ROW_PACKET, 10'd1,   16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_TOO_SHORT},
		// Wrong protocol, then wrong destination port.
		'{ROW_PACKET, 10'd40,  16'd53,   8'd6,  FILL_RAND, 1'b1, dqr_pkg::ST_NOT_QUERY},
		'{ROW_PACKET, 10'd40,  16'd54,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_NOT_QUERY},
		// First length that carries the DNS flags byte.
		'{ROW_PACKET, 10'd31,  16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_READY},
		'{ROW_DRAIN,  10'd0,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		// A ready packet partly read and then dropped by the next load.
		'{ROW_PACKET, 10'd30,  16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_READY},
		'{ROW_READ,   10'd5,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_PACKET, 10'd29,  16'd53,   8'd17, FILL_RAND, 1'b1, dqr_pkg::ST_READY},
		'{ROW_DRAIN,  10'd0,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		// Payload chosen so the UDP checksum computes to zero and goes out as all ones.
		'{ROW_PACKET, 10'd34,  16'd53,   8'd17, FILL_CK0,  1'b1, dqr_pkg::ST_READY},
		'{ROW_DRAIN,  10'd0,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		// Match registers at their upper extremes with an all-ones packet.
		'{ROW_REG,    ROW_PORT_IDX,  16'hffff, 8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_REG,    ROW_PROTO_IDX, 16'h00ff, 8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_PACKET, 10'd33,  16'hffff, 8'hff, FILL_ONES, 1'b1, dqr_pkg::ST_READY},
		'{ROW_DRAIN,  10'd0,   16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		// Match registers at zero, a full-size all-zero packet with its header read
		// back, then one byte too many.
		'{ROW_REG,    ROW_PORT_IDX,  16'd0,    8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_REG,    ROW_PROTO_IDX, 16'd0,    8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_PACKET, 10'd512, 16'd0,    8'd0,  FILL_ZERO, 1'b1, dqr_pkg::ST_READY},
		'{ROW_READ,   10'd32,  16'd0,    8'd0,  FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_PACKET, 10'd513, 16'd0,    8'd0,  FILL_ZERO, 1'b1, dqr_pkg::ST_TOO_LONG},
		'{ROW_READ,   10'd1,   16'd0,    8'd0,  FILL_RAND, 1'b1, dqr_pkg::ST_EMPTY},
		// Back to a DNS query over UDP for the random part.
		'{ROW_REG,    ROW_PORT_IDX,  16'd53,   8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA},
		'{ROW_REG,    ROW_PROTO_IDX, 16'd17,   8'd0, FILL_RAND, 1'b0, dqr_pkg::ST_DATA}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           kind = 1'b0;
	logic [7:0]                     data_byte = 8'h00;
	logic                           last_byte = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     out_byte;
	logic                           out_last;
	logic [2:0]                     status;
	logic [9:0]                     packet_length;
	logic                           cfg_wr_en = 1'b0;
	logic [dqr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dqr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: the packet as the block should hold it after the rewrite,
	// the load and read positions, and its own copy of the match registers.
	logic [7:0]  pkt_mem [MAX_BYTES];
	int unsigned fill_cnt = 0;
	int unsigned rd_ptr = 0;
	int unsigned held_len = 0;
	bit          held_ready = 1'b0;
	bit          overrun = 1'b0;
	logic [15:0] port_reg = dqr_pkg::RST_MATCH_PORT;
	logic [7:0]  proto_reg = dqr_pkg::UDP_PROTO;

	reply_t      pending_replies [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned reflected = 0;
	int unsigned refused = 0;
	int unsigned bytes_out = 0;
	// While set, neither side idles.
	bit          calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dns_query_reflect_rewriter_unit #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) i_dut (.*);

	// Adds the stored bytes [from, upto) to acc as big-endian 16-bit words; an odd
	// trailing byte is padded with zero.
	function automatic int unsigned word_sum(input int unsigned acc, input int unsigned from,
			input int unsigned upto);
		for (int unsigned i = from; i < upto && i < MAX_BYTES; i += 2) begin
			acc += {pkt_mem[i], (i + 1 < upto && i + 1 < MAX_BYTES) ? pkt_mem[i + 1] : 8'h00};
		end
		return acc;
	endfunction

	// End-around carry fold to 16 bits, then the ones' complement.
	function automatic logic [15:0] ones_fold(input int unsigned s);
		while (s >> 16 != 0)
			s = (s & 32'hffff) + (s >> 16);
		return ~s[15:0];
	endfunction

	// Advances the predictor by one accepted item and gives the result it causes.
	function automatic void reflect_step(input logic k, input logic [7:0] b, input logic l,
			output bit has, output reply_t r);
		int unsigned          len;
		int unsigned          acc;
		logic [7:0]           t;
		logic [15:0]          ck;
		dqr_pkg::dqr_status_t st;
		r = '0;
		has = 1'b1;
		if (k == KIND_READ) begin
			if (!held_ready || rd_ptr >= held_len) begin
				held_ready = 1'b0;
				r.st = dqr_pkg::ST_EMPTY;
				return;
			end
			r.data = pkt_mem[rd_ptr];
			r.st = dqr_pkg::ST_DATA;
			rd_ptr++;
			bytes_out++;
			if (rd_ptr >= held_len) begin
				r.fin = 1'b1;
				held_ready = 1'b0;
			end
			return;
		end

		// Any load drops a packet that is waiting to be read.
		held_ready = 1'b0;
		if (fill_cnt < MAX_BYTES) begin
			pkt_mem[fill_cnt] = b;
			fill_cnt++;
		end else
			overrun = 1'b1;
		if (!l) begin
			has = 1'b0;
			return;
		end

		len = fill_cnt;
		if (overrun)
			st = dqr_pkg::ST_TOO_LONG;
		else if (len < dqr_pkg::MIN_PKT_BYTES)
			st = dqr_pkg::ST_TOO_SHORT;
		else if (pkt_mem[dqr_pkg::OFF_PROTO] != proto_reg ||
				{pkt_mem[dqr_pkg::OFF_DST_PORT_HI], pkt_mem[dqr_pkg::OFF_DST_PORT_LO]}
				!= port_reg)
			st = dqr_pkg::ST_NOT_QUERY;
		else
			st = dqr_pkg::ST_READY;
		fill_cnt = 0;
		overrun = 1'b0;
		rd_ptr = 0;
		r.st = st;
		if (st != dqr_pkg::ST_READY) begin
			refused++;
			return;
		end

		// Turn the query around: swap addresses and ports, mark it a response.
		for (int i = 0; i < 4; i++) begin
			t = pkt_mem[dqr_pkg::OFF_SRC_ADDR + i];
			pkt_mem[dqr_pkg::OFF_SRC_ADDR + i] = pkt_mem[dqr_pkg::OFF_DST_ADDR + i];
			pkt_mem[dqr_pkg::OFF_DST_ADDR + i] = t;
		end
		for (int i = 0; i < 2; i++) begin
			t = pkt_mem[dqr_pkg::OFF_SRC_PORT + i];
			pkt_mem[dqr_pkg::OFF_SRC_PORT + i] = pkt_mem[dqr_pkg::OFF_DST_PORT_HI + i];
			pkt_mem[dqr_pkg::OFF_DST_PORT_HI + i] = t;
		end
		if (len > dqr_pkg::OFF_DNS_FLAGS)
			pkt_mem[dqr_pkg::OFF_DNS_FLAGS] |= dqr_pkg::DNS_QR_BIT;

		// IPv4 header checksum over the 20 header bytes with its own field zeroed.
		pkt_mem[dqr_pkg::OFF_HCK_HI] = 8'h00;
		pkt_mem[dqr_pkg::OFF_HCK_LO] = 8'h00;
		ck = ones_fold(word_sum(0, 0, dqr_pkg::IP_HDR_BYTES));
		{pkt_mem[dqr_pkg::OFF_HCK_HI], pkt_mem[dqr_pkg::OFF_HCK_LO]} = ck;

		// UDP checksum over the pseudo-header and the whole UDP segment.
		pkt_mem[dqr_pkg::OFF_UCK_HI] = 8'h00;
		pkt_mem[dqr_pkg::OFF_UCK_LO] = 8'h00;
		acc = word_sum(0, dqr_pkg::OFF_SRC_ADDR, dqr_pkg::IP_HDR_BYTES) + dqr_pkg::UDP_PROTO +
			((len - dqr_pkg::IP_HDR_BYTES) & 32'hffff);
		ck = ones_fold(word_sum(acc, dqr_pkg::IP_HDR_BYTES, len));
		if (ck == 16'h0000)
			ck = 16'hffff;
		{pkt_mem[dqr_pkg::OFF_UCK_HI], pkt_mem[dqr_pkg::OFF_UCK_LO]} = ck;

		held_len = len;
		held_ready = 1'b1;
		r.len = len[9:0];
		reflected++;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Offers one item and holds it until the block takes it. The valid is left high
	// afterwards so that back-to-back items never lower and raise it in one step.
	task automatic send_item(input logic k, input logic [7:0] b, input logic l,
			input bit use_typed = 1'b0, input reply_t typed_r = '0);
		bit     has;
		reply_t r;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		items_sent++;
		reflect_step(k, b, l, has, r);
		if (has)
			pending_replies.push_back(use_typed ? typed_r : r);
	endtask

	task automatic read_item(input bit use_typed = 1'b0);
		send_item(KIND_READ, 8'($urandom), 1'($urandom), use_typed, EMPTY_REPLY);
	endtask

	// Loads a whole packet with the given protocol and destination port in place.
	task automatic load_packet(input int unsigned len, input logic [15:0] port,
			input logic [7:0] proto, input fill_t fill, input bit typed = 1'b0,
			input dqr_pkg::dqr_status_t st = dqr_pkg::ST_READY);
		logic [7:0]  pkt_bytes [$];
		int unsigned acc;
		reply_t      tr;
		for (int unsigned i = 0; i < len; i++)
			pkt_bytes.push_back(fill == FILL_ZERO ? 8'h00 :
				fill == FILL_ONES ? 8'hff : 8'($urandom));
		if (len > dqr_pkg::OFF_PROTO)
			pkt_bytes[dqr_pkg::OFF_PROTO] = proto;
		if (len > dqr_pkg::OFF_DST_PORT_LO)
			{pkt_bytes[dqr_pkg::OFF_DST_PORT_HI], pkt_bytes[dqr_pkg::OFF_DST_PORT_LO]} = port;
		if (fill == FILL_CK0) begin
			// Sum everything the UDP checksum covers except the last word, as it will
			// look after the rewrite, then pick the last word so the total folds to all
			// ones. Needs an even length that reaches past the DNS flags byte.
			acc = dqr_pkg::UDP_PROTO + len - dqr_pkg::IP_HDR_BYTES;
			for (int unsigned i = dqr_pkg::OFF_SRC_ADDR; i < len - 2; i += 2) begin
				if (i == dqr_pkg::OFF_UCK_HI)
					continue;
				acc += {i == dqr_pkg::OFF_DNS_FLAGS ? pkt_bytes[i] | dqr_pkg::DNS_QR_BIT :
					pkt_bytes[i], pkt_bytes[i + 1]};
			end
			{pkt_bytes[len - 2], pkt_bytes[len - 1]} = 16'hffff - ~ones_fold(acc);
		end
		tr = '0;
		tr.st = st;
		if (st == dqr_pkg::ST_READY)
			tr.len = len[9:0];
		for (int unsigned i = 0; i < len; i++)
			send_item(KIND_LOAD, pkt_bytes[i], i == len - 1, typed, tr);
	endtask

	// Registers change only with the block idle: every result in, then the quiet
	// settle cycles for anything still moving through the pipeline.
	task automatic set_reg(input logic [dqr_pkg::CFG_IDX_W-1:0] idx,
			input logic [dqr_pkg::CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == dqr_pkg::REG_MATCH_PORT)
			port_reg = val;
		else
			proto_reg = val[7:0];
	endtask

	// The receiver stalls at random except during the calm stretch.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	// Every result taken by the receiver is checked against the oldest expectation.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_replies.size() == 0)
				flag_mismatch("result arrived with nothing expected");
			else begin
				want = pending_replies.pop_front();
				if (out_byte !== want.data)
					flag_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
				if (out_last !== want.fin)
					flag_mismatch($sformatf("out_last %b, expected %b", out_last, want.fin));
				if (status !== want.st)
					flag_mismatch($sformatf("status %0d, expected %s", status, want.st.name()));
				if (packet_length !== want.len)
					flag_mismatch($sformatf("packet_length %0d, expected %0d",
						packet_length, want.len));
			end
		end
	end

	initial begin
		plan_row_t   row;
		int unsigned start_items;
		int unsigned pick;
		int unsigned len;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the plan row by row.
		foreach (plan[i]) begin
			row = plan[i];
			case (row.what)
				ROW_PACKET: load_packet(row.num, row.port, row.proto, row.fill, row.typed,
					row.st);
				ROW_READ: repeat (row.num) read_item(row.typed);
				ROW_DRAIN: while (held_ready) read_item();
				ROW_REG: set_reg(row.num[dqr_pkg::CFG_IDX_W-1:0], row.port);
				default: begin
				end
			endcase
		end

		// Random part. Most of it is well-formed queries that get reflected and read
		// back, mixed with short, long and non-matching packets, stray reads, partly
		// read packets that the next load drops, and register changes. A stretch in
		// the middle runs with no idling on either side.
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			calm = (items_sent - start_items >= 150) && (items_sent - start_items < 300);
			pick = $urandom_range(99);
			if (pick < 3) begin
				if ($urandom_range(1))
					set_reg(dqr_pkg::REG_MATCH_PORT,
						$urandom_range(3) == 0 ? 16'hffff : 16'($urandom));
				else
					set_reg(dqr_pkg::REG_MATCH_PROTO,
						{8'h00, $urandom_range(3) == 0 ? dqr_pkg::UDP_PROTO : 8'($urandom)});
			end else if (pick < 4)
				load_packet($urandom_range(MAX_BYTES + 1, MAX_BYTES + 6), port_reg, proto_reg,
					FILL_RAND);
			else if (pick < 12)
				load_packet($urandom_range(1, dqr_pkg::MIN_PKT_BYTES - 1), port_reg, proto_reg,
					FILL_RAND);
			else if (pick < 22) begin
				// A single flipped bit in the port or the protocol is enough to refuse it.
				if ($urandom_range(1))
					load_packet($urandom_range(dqr_pkg::MIN_PKT_BYTES, 72),
						port_reg ^ (16'd1 << $urandom_range(15)), proto_reg, FILL_RAND);
				else
					load_packet($urandom_range(dqr_pkg::MIN_PKT_BYTES, 72), port_reg,
						proto_reg ^ (8'd1 << $urandom_range(7)), FILL_RAND);
			end else if (pick < 30)
				repeat ($urandom_range(1, 3)) read_item();
			else begin
				len = ($urandom_range(49) == 0) ? $urandom_range(200, MAX_BYTES) :
					$urandom_range(dqr_pkg::MIN_PKT_BYTES, 72);
				load_packet(len, port_reg, proto_reg, FILL_RAND);
				pick = $urandom_range(9);
				if (pick < 7) begin
					while (held_ready) read_item();
					if ($urandom_range(2) == 0)
						read_item();
				end else if (pick < 9)
					repeat ($urandom_range(len - 1)) read_item();
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		for (int n = 0; n < 2000 && pending_replies.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_replies.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived",
				pending_replies.size()));

		$display("Sent %0d items: %0d packets reflected, %0d refused, %0d rewritten bytes read.",
			items_sent, reflected, refused, bytes_out);
		$display("Match registers went through both extremes and random values between phases.");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
